/* rtl/wics_pkg.sv */
package wics_pkg;
   localparam int AGES = 64;
   localparam int AW = $clog2(AGES);
   localparam int CW = $clog2(AGES + 1);
   localparam int SUMW = 16 + CW;
   localparam int PRODW = SUMW + 32;
   localparam int CNTW = 6;

   localparam logic [0:0] CSR_AGE_CAP = 1'b0;
   localparam logic [0:0] CSR_USE_UNIFORM = 1'b1;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_CLAMPED = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE, S_SUM, S_MUL, S_DIV, S_OUT, S_ERR
   } state_type;

   typedef struct packed {
      logic load;
      logic sum_clr;
      logic sum_step;
      logic share_start;
      logic div_start;
      logic next_age;
   } cmd_type;

   typedef struct packed {
      logic sum_done;
      logic div_done;
      logic last_age;
      logic invalid;
   } sts_type;
endpackage

/* rtl/wics_if.sv */
interface wics_req_if;
   import wics_pkg::*;
   logic valid;
   logic ready;
   logic kind;
   logic [5:0] weight_index;
   logic [15:0] weight_value;
   logic [7:0] lower_age;
   logic [7:0] upper_age;
   logic [31:0] interval_count;
   modport source (output valid, kind, weight_index, weight_value, lower_age, upper_age,
      interval_count, input ready);
   modport sink (input valid, kind, weight_index, weight_value, lower_age, upper_age,
      interval_count, output ready);
endinterface

interface wics_rsp_if;
   logic valid;
   logic ready;
   logic [5:0] age;
   logic [31:0] share;
   logic [1:0] status;
   logic last;
   modport source (output valid, age, share, status, last, input ready);
   modport sink (input valid, age, share, status, last, output ready);
endinterface

interface wics_csr_if;
   logic valid;
   logic ready;
   logic index;
   logic [6:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/wics_ram.sv */
module wics_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

/* rtl/wics_datapath.sv */
module wics_datapath
   import wics_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic        w_we,
   input  logic [AW-1:0] w_addr,
   input  logic [15:0] w_data,
   input  logic [6:0]  age_cap,
   input  logic        use_uniform,
   input  logic [7:0]  lower_age,
   input  logic [7:0]  upper_age,
   input  logic [31:0] count,
   output logic [5:0]  age,
   output logic [31:0] share,
   output logic [1:0]  status
);
   logic [AW-1:0] lo_ff, lo_in, hi_ff, hi_in, a_ff, a_in, a_next, ra;
   logic [31:0] count_ff;
   logic [1:0] status_ff, status_in;
   logic invalid_ff, invalid_in;
   logic uni_ff;
   logic [SUMW-1:0] sum_ff;
   logic [15:0] rdata;
   logic [15:0] w;
   logic [AGES-1:0] wvalid_ff;
   logic rvalid_ff;
   logic [PRODW-1:0] rem_ff, den_ff;
   logic [31:0] q_ff;
   logic [CNTW-1:0] bit_ff;
   logic busy_ff;
   logic [PRODW:0] trial;
   logic [7:0] limit, up_c;

   wics_ram #(.WIDTH(16), .DEPTH(AGES)) u_ram (
      .clock(clock), .we(w_we), .waddr(w_addr), .wdata(w_data),
      .raddr(ra), .rdata(rdata));

   // read address leads the age register so rdata always holds the weight of a_ff
   assign ra = a_next;

   always_comb begin
      limit = (age_cap > 7'(AGES)) ? 8'(AGES) : {1'b0, age_cap};
      status_in = ST_OK;
      up_c = upper_age;
      if (upper_age > limit) begin
         up_c = limit;
         status_in = ST_CLAMPED;
      end
      invalid_in = lower_age >= up_c;
      lo_in = lower_age[AW-1:0];
      hi_in = AW'(up_c - 8'd1);
      a_in = a_ff + AW'(1);
      a_next = a_ff;
      if (cmd.sum_clr) begin
         a_next = lo_in;
      end else if (cmd.sum_step) begin
         // rewind to lower after the last weight for the share pass
         a_next = (a_ff == hi_ff) ? lo_ff : a_in;
      end else if (cmd.next_age) begin
         a_next = a_in;
      end
   end

   // an unwritten entry reads as zero weight
   always_ff @(posedge clock) begin
      if (reset) wvalid_ff <= '0;
      else if (w_we) wvalid_ff[w_addr] <= 1'b1;
   end

   assign w = uni_ff ? 16'd1 : (rvalid_ff ? rdata : 16'd0);
   assign trial = {1'b0, rem_ff} - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      a_ff <= a_next;
      rvalid_ff <= wvalid_ff[ra];
      if (cmd.load) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         count_ff <= count;
         status_ff <= status_in;
         invalid_ff <= invalid_in;
         uni_ff <= use_uniform;
      end
      if (cmd.sum_clr) begin
         sum_ff <= '0;
      end else if (cmd.sum_step) begin
         sum_ff <= sum_ff + SUMW'(w);
      end
      if (cmd.share_start) begin
         // product count*w, then restoring divide by sum
         rem_ff <= PRODW'(count_ff) * PRODW'(w);
      end
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         den_ff <= PRODW'(sum_ff) << 31;
         q_ff <= '0;
         bit_ff <= '0;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         if (!trial[PRODW]) rem_ff <= trial[PRODW-1:0];
         q_ff <= {q_ff[30:0], ~trial[PRODW]};
         den_ff <= den_ff >> 1;
         bit_ff <= bit_ff + CNTW'(1);
         if (bit_ff == CNTW'(31)) busy_ff <= 1'b0;
      end
   end

   assign sts.sum_done = a_ff == hi_ff;
   assign sts.div_done = !busy_ff && !cmd.div_start;
   assign sts.last_age = a_ff == hi_ff;
   assign sts.invalid = invalid_ff;
   assign age = invalid_ff ? 6'd0 : 6'(a_ff);
   assign share = (invalid_ff || sum_ff == '0) ? 32'd0 : q_ff;
   assign status = invalid_ff ? ST_INVALID : status_ff;
endmodule

/* rtl/wics_ctrl.sv */
module wics_ctrl
   import wics_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_fire,
   input  logic    req_kind,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    req_ready,
   output logic    rsp_valid,
   output logic    rsp_last
);
   state_type state_ff, state_in;
   logic dstart_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dstart_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dstart_ff <= cmd.share_start;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.div_start = dstart_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rsp_last = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_fire && req_kind) begin
               cmd.load = 1'b1;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (sts.invalid) state_in = S_ERR;
            else begin
               cmd.sum_step = 1'b1;
               if (sts.sum_done) state_in = S_MUL;
            end
         end
         S_MUL: state_in = S_DIV;
         S_DIV: if (sts.div_done) state_in = S_OUT;
         S_OUT: begin
            rsp_valid = 1'b1;
            rsp_last = sts.last_age;
            if (rsp_ready) begin
               if (sts.last_age) state_in = S_IDLE;
               else begin
                  cmd.next_age = 1'b1;
                  state_in = S_MUL;
               end
            end
         end
         S_ERR: begin
            rsp_valid = 1'b1;
            rsp_last = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // sum clears and restarts from lower together with load; multiply reads current age
      if (state_ff == S_IDLE && state_in == S_SUM) cmd.sum_clr = 1'b1;
      if (state_ff == S_MUL) cmd.share_start = 1'b1;
   end

`ifndef NO_ASSERTIONS
   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !rsp_valid) else $error("rsp in idle");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready) else $error("ready while busy");
   a_div_follow: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |=> state_ff == S_DIV) else $error("mul to div");
`endif
endmodule

/* rtl/weighted_interval_count_splitter.sv */
// flow: a sum pass over the n ages of the interval, then for each share a multiply
// step, a restoring divide and an output step
// throughput: one interval at a time, no new item accepted until the last share is taken
// weight writes are accepted only while idle; an invalid interval answers with one item
// reset (synchronous, active high): age_cap 64, use_uniform 1, table zero
module weighted_interval_count_splitter
   import wics_pkg::*;
(
   input logic clock,
   input logic reset,
   wics_req_if.sink req,
   wics_rsp_if.source rsp,
   wics_csr_if.sink csr
);
   logic [6:0] age_cap_ff;
   logic use_uniform_ff;
   logic w_we, req_fire;
   cmd_type cmd;
   sts_type sts;
   logic [15:0] w_data;

   assign csr.ready = 1'b1;
   assign req_fire = req.valid && req.ready;
   assign w_we = req_fire && !req.kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         age_cap_ff <= 7'd64;
         use_uniform_ff <= 1'b1;
      end else if (csr.valid) begin
         if (csr.index == CSR_AGE_CAP) age_cap_ff <= csr.data;
         else use_uniform_ff <= csr.data[0];
      end
   end

   assign w_data = req.weight_value;

   wics_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .req_kind(req.kind),
      .rsp_ready(rsp.ready), .sts(sts), .cmd(cmd), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_last(rsp.last));

   wics_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .w_we(w_we), .w_addr(req.weight_index[AW-1:0]), .w_data(w_data),
      .age_cap(age_cap_ff), .use_uniform(use_uniform_ff),
      .lower_age(req.lower_age), .upper_age(req.upper_age), .count(req.interval_count),
      .age(rsp.age), .share(rsp.share), .status(rsp.status));
endmodule

/* test/wics_tb_if.sv */
`timescale 1ns / 1ps
package wics_tb_pkg;
   typedef struct packed {
      logic [5:0]  age;
      logic [31:0] share;
      logic [1:0]  status;
      logic        last;
   } share_item_type;
endpackage

/* test/wics_checker.sv */
`timescale 1ns / 1ps
module wics_checker
   import wics_pkg::*;
   import wics_tb_pkg::*;
(
   input logic clock,
   input logic reset,
   wics_req_if req,
   wics_rsp_if rsp,
   wics_csr_if csr,
   output int fail_count,
   output int pending
);
   logic [15:0] weights [AGES];
   logic [6:0] age_cap_q;
   logic uniform_q;
   share_item_type share_q[$];

   function automatic logic [15:0] age_weight(int a);
      if (uniform_q) begin
         return 16'd1;
      end
      return weights[a];
   endfunction

   task automatic predict_split(logic [7:0] lower, logic [7:0] upper_in, logic [31:0] count);
      int limit;
      int upper;
      logic [1:0] status;
      logic [63:0] total;
      logic [63:0] part;
      share_item_type item;
      limit = (age_cap_q > AGES) ? AGES : age_cap_q;
      upper = upper_in;
      status = ST_OK;
      total = '0;
      if (upper > limit) begin
         upper = limit;
         status = ST_CLAMPED;
      end
      if (lower >= upper) begin
         item = '{age: '0, share: '0, status: ST_INVALID, last: 1'b1};
         share_q.push_back(item);
         return;
      end
      for (int a = lower; a < upper; a++) total += age_weight(a);
      for (int a = lower; a < upper; a++) begin
         part = (total == 0) ? 64'd0 : (64'(count) * age_weight(a)) / total;
         item.age = a[5:0];
         item.share = part[31:0];
         item.status = status;
         item.last = (a + 1 == upper);
         share_q.push_back(item);
      end
   endtask

   always @(posedge clock) begin
      share_item_type got;
      share_item_type exp;
      if (reset) begin
         for (int i = 0; i < AGES; i++) weights[i] <= '0;
         age_cap_q <= 7'd64;
         uniform_q <= 1'b1;
         share_q.delete();
         fail_count <= 0;
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index == CSR_AGE_CAP) age_cap_q <= csr.data;
            else uniform_q <= csr.data[0];
         end
         if (req.valid && req.ready) begin
            if (!req.kind) weights[req.weight_index] <= req.weight_value;
            else predict_split(req.lower_age, req.upper_age, req.interval_count);
         end
         if (rsp.valid && rsp.ready) begin
            got = '{age: rsp.age, share: rsp.share, status: rsp.status, last: rsp.last};
            if (share_q.size() == 0) begin
               $display("%0t: unexpected share item: expected none actual %p", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               exp = share_q.pop_front();
               if (got !== exp) begin
                  $display("%0t: share mismatch: expected %p actual %p", $time, exp, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= share_q.size();
   end
endmodule

/* test/tb_weighted_interval_count_splitter.sv */
`timescale 1ns / 1ps
module tb_weighted_interval_count_splitter;
   import wics_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int fail_count;
   int pending;

   wics_req_if req();
   wics_rsp_if rsp();
   wics_csr_if csr();

   weighted_interval_count_splitter dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   wics_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr),
      .fail_count(fail_count), .pending(pending)
   );

   always #2 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.kind = 1'b0;
      req.weight_index = '0;
      req.weight_value = '0;
      req.lower_age = '0;
      req.upper_age = '0;
      req.interval_count = '0;
      csr.valid = 1'b0;
      csr.index = CSR_AGE_CAP;
      csr.data = '0;
   end

   // receiver stalls a random number of cycles per item
   initial begin
      int gap;
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         rsp.ready = 1'b0;
         repeat (gap) @(negedge clock);
         rsp.ready = 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic csr_write(logic idx, logic [6:0] value);
      csr.valid = 1'b1;
      csr.index = idx;
      csr.data = value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   task automatic send_item(logic kind, logic [5:0] widx, logic [15:0] wval,
                            logic [7:0] lo, logic [7:0] hi, logic [31:0] count);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      repeat (gap) @(negedge clock);
      req.valid = 1'b1;
      req.kind = kind;
      req.weight_index = widx;
      req.weight_value = wval;
      req.lower_age = lo;
      req.upper_age = hi;
      req.interval_count = count;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   task automatic write_weight(logic [5:0] widx, logic [15:0] wval);
      send_item(1'b0, widx, wval, 8'($urandom), 8'($urandom), 32'($urandom));
   endtask

   task automatic split(logic [7:0] lo, logic [7:0] hi, logic [31:0] count);
      send_item(1'b1, 6'($urandom), 16'($urandom), lo, hi, count);
   endtask

   // mostly short intervals so the run stays quick, a few wide ones
   task automatic random_split();
      int lo;
      int hi;
      int pick;
      pick = $urandom_range(0, 9);
      lo = $urandom_range(0, 63);
      if (pick == 0) begin
         split(8'($urandom), 8'($urandom), 32'($urandom));
      end else if (pick == 1) begin
         split(8'($urandom_range(0, 2)), 8'($urandom_range(62, 255)), 32'($urandom));
      end else begin
         hi = lo + $urandom_range(0, 6);
         split(8'(lo), 8'(hi), (pick == 2) ? 32'hFFFF_FFFF : 32'($urandom));
      end
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: uniform at reset, edges of the fields
      split(8'd0, 8'd64, 32'hFFFF_FFFF);
      split(8'd10, 8'd11, 32'd0);
      split(8'd60, 8'd255, 32'd1000);
      split(8'd5, 8'd5, 32'd7);
      split(8'd255, 8'd0, 32'd7);
      split(8'd64, 8'd200, 32'd7);
      split(8'd0, 8'd3, 32'd2);
      // zero weight sum with an empty table, then splits with a loaded table
      drain();
      csr_write(CSR_USE_UNIFORM, 7'd0);
      split(8'd0, 8'd4, 32'hFFFF_FFFF);
      write_weight(6'd0, 16'hFFFF);
      write_weight(6'd63, 16'hFFFF);
      write_weight(6'd1, 16'd1);
      write_weight(6'd2, 16'h5555);
      split(8'd0, 8'd4, 32'hFFFF_FFFF);
      split(8'd62, 8'd64, 32'h8000_0001);
      drain();
      csr_write(CSR_AGE_CAP, 7'd0);
      split(8'd0, 8'd1, 32'd5);
      drain();
      csr_write(CSR_AGE_CAP, 7'd127);
      split(8'd60, 8'd100, 32'd12345);
      drain();
      csr_write(CSR_AGE_CAP, 7'd1);
      split(8'd0, 8'd9, 32'd99);

      for (int phase = 0; phase < 4; phase++) begin
         drain();
         csr_write(CSR_AGE_CAP, (phase == 3) ? 7'd64 : 7'($urandom_range(1, 127)));
         csr_write(CSR_USE_UNIFORM, 7'(phase % 2));
         for (int i = 0; i < 38; i++) begin
            if ($urandom_range(0, 2) == 0) write_weight(6'($urandom), 16'($urandom));
            else random_split();
         end
      end
      drain();

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
